// ===== sv/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

// ===== sv/tsc_pkg.sv =====
// Types and constants of the time-signature tick converter.
`timescale 1ns / 1ps
package tsc_pkg;

    localparam logic [30:0] TICK_MAX = 31'h7FFF_FFFF;

    typedef enum logic [1:0] {
        KIND_SET,
        KIND_REMOVE,
        KIND_TO_TIME,
        KIND_TO_TICK
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_NO_SIG,
        ST_FULL,
        ST_OVF
    } status_t;

    typedef struct packed {
        logic [30:0] start;
        logic [6:0]  den;
        logic [6:0]  num;
        logic [15:0] bar;
    } entry_t;

    localparam entry_t DEFAULT_ENTRY = '{start: 31'd0, den: 7'd4, num: 7'd4, bar: 16'd0};

    typedef struct packed {
        kind_t       kind;
        logic [15:0] bar;
        logic [6:0]  num;
        logic [6:0]  den;
        logic [15:0] beat;
        logic [30:0] tick;
        logic        imm;
        status_t     imm_status;
        logic [30:0] imm_total;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } front_stat_t;

    typedef enum logic [4:0] {
        BK_INIT, BK_IDLE, BK_SCAN_RD, BK_SCAN_CHK,
        BK_SHU_RD, BK_SHU_WR, BK_INS_WR, BK_SHD_RD, BK_SHD_WR,
        BK_REC_START, BK_REC_PREV, BK_REC_RD, BK_REC_LEN, BK_REC_MUL,
        BK_REC_ADD, BK_REC_DONE,
        BK_TK_BL, BK_TK_TL, BK_TK_Q1, BK_TK_Q2, BK_TK_FIN,
        BK_TM_BL, BK_TM_TL, BK_TM_M1, BK_TM_M2, BK_TM_ADD, BK_TM_FIN,
        BK_DIV_WAIT, BK_OUT
    } back_state_t;

endpackage

// ===== sv/tsc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tsc_ram #(
    parameter int WIDTH = 61,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== sv/tsc_div.sv =====
// Restoring divider, one quotient bit per cycle, 32-bit operands.
`timescale 1ns / 1ps
module tsc_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [31:0] remainder
);
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] q_reg, q_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    assign trial = {r_reg, q_reg[31]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            r_next    = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[30:0], ge};
            r_next   = ge ? diff[31:0] : trial[31:0];
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;
endmodule

// ===== sv/tsc_front.sv =====
// Input side: takes transactions, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module tsc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [79:0]         s_tdata,
    input  logic [1:0]          s_tuser,
    input  logic                pop,
    output tsc_pkg::cmd_t       head,
    output tsc_pkg::front_stat_t stat
);
    import tsc_pkg::*;

    cmd_t       cls;
    cmd_t       q_mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] level_reg, level_next;
    logic       push;

    always_comb
    begin
        cls.kind       = kind_t'(s_tuser);
        cls.bar        = s_tdata[15:0];
        cls.num        = s_tdata[22:16];
        cls.den        = s_tdata[29:23];
        cls.beat       = s_tdata[45:30];
        cls.tick       = s_tdata[76:46];
        cls.imm        = 1'b0;
        cls.imm_status = ST_OK;
        cls.imm_total  = '0;
        unique case (cls.kind)
            KIND_SET:
            begin
                cls.imm = (cls.num == 7'd0) || (cls.den == 7'd0);
            end
            KIND_REMOVE:
            begin
                cls.imm        = cls.bar == 16'd0;
                cls.imm_status = ST_NO_SIG;
            end
            KIND_TO_TIME:
            begin
                cls.imm = 1'b0;
            end
            KIND_TO_TICK:
            begin
                // Measure zero and beat zero pass the tick straight through.
                cls.imm       = (cls.bar == 16'd0) && (cls.beat == 16'd0);
                cls.imm_total = cls.tick;
            end
            default:
            begin
                cls.imm = 1'b0;
            end
        endcase
    end

    assign s_tready   = level_reg != 2'd2;
    assign push       = s_tvalid && s_tready;
    assign stat.empty = level_reg == 2'd0;
    assign stat.full  = level_reg == 2'd2;
    assign head       = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        level_next  = level_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= cls;
        end
    end
endmodule

// ===== sv/tsc_back.sv =====
// Back end: table edits, start-tick recomputation, conversions and the output register.
`timescale 1ns / 1ps
module tsc_back #(
    parameter int MAX_CHANGES = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [15:0]          tpq,
    input  logic                 cfg_we,
    input  tsc_pkg::cmd_t        head,
    input  tsc_pkg::front_stat_t fr_stat,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [111:0]         m_tdata
);
    import tsc_pkg::*;

    localparam int IW = $clog2(MAX_CHANGES);
    localparam int CW = $clog2(MAX_CHANGES + 1);

    back_state_t  state_reg, state_next;
    back_state_t  ret_reg, ret_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] p_reg, p_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pend_reg, pend_next;
    logic          cfg_op_reg, cfg_op_next;
    logic          ovf_reg, ovf_next;
    cmd_t          cmd_reg, cmd_next;
    entry_t        sel_reg, sel_next;
    entry_t        prev_reg, prev_next;
    entry_t        cur_reg, cur_next;
    logic [24:0]   bl_reg, bl_next;
    logic [24:0]   tl_reg, tl_next;
    logic [40:0]   prod_reg, prod_next;
    logic [42:0]   acc_reg, acc_next;
    status_t       res_status_reg, res_status_next;
    logic [30:0]   res_meas_reg, res_meas_next;
    logic [15:0]   res_bib_reg, res_bib_next;
    logic [30:0]   res_tib_reg, res_tib_next;
    logic [30:0]   res_total_reg, res_total_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [111:0]  m_tdata_reg, m_tdata_next;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    entry_t        ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [$bits(entry_t)-1:0] ram_rdata;
    entry_t        e;

    logic          div_start;
    logic [31:0]   div_dvd;
    logic [31:0]   div_dvs;
    logic          div_done;
    logic [31:0]   div_q;
    logic [31:0]   div_r;

    logic          idx_last;
    logic          tbl_full;
    logic          bar_lt;
    logic          bar_eq;
    logic          set_same;
    logic          rm_hit;
    logic          out_free;
    logic [42:0]   rec_sum;
    logic [30:0]   rec_start;
    logic [31:0]   meas_sum;
    logic [15:0]   bar_diff;

    function automatic logic [24:0] bar_dvd(logic [15:0] t, logic [6:0] n);
        return 25'({t, 2'b00}) * 25'(n);
    endfunction

    tsc_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_CHANGES)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tsc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign e        = entry_t'(ram_rdata);
    assign idx_last = (CW'(idx_reg) + CW'(1)) >= count_reg;
    assign tbl_full = count_reg == CW'(MAX_CHANGES);
    assign bar_lt   = e.bar < cmd_reg.bar;
    assign bar_eq   = e.bar == cmd_reg.bar;
    assign set_same = (e.num == cmd_reg.num) && (e.den == cmd_reg.den);
    assign rm_hit   = (idx_reg != '0) && bar_eq;
    assign out_free = !m_tvalid_reg || m_tready;
    assign rec_sum  = 43'(prev_reg.start) + 43'(prod_reg);
    assign rec_start = (rec_sum > 43'(TICK_MAX)) ? TICK_MAX : rec_sum[30:0];
    assign meas_sum = 32'(sel_reg.bar) + div_q;
    assign bar_diff = (state_reg == BK_REC_MUL) ? (cur_reg.bar - prev_reg.bar)
                                                : (cmd_reg.bar - sel_reg.bar);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_INIT:      state_next = BK_IDLE;
            BK_IDLE:
            begin
                if (pend_reg)
                begin
                    state_next = BK_REC_START;
                end
                else if (!fr_stat.empty)
                begin
                    state_next = head.imm ? BK_OUT : BK_SCAN_RD;
                end
            end
            BK_SCAN_RD:   state_next = BK_SCAN_CHK;
            BK_SCAN_CHK:
            begin
                unique case (cmd_reg.kind)
                    KIND_SET:
                    begin
                        if (bar_lt)
                        begin
                            if (!idx_last)
                                state_next = BK_SCAN_RD;
                            else
                                state_next = tbl_full ? BK_OUT : BK_INS_WR;
                        end
                        else if (bar_eq)
                        begin
                            state_next = set_same ? BK_OUT : BK_REC_START;
                        end
                        else
                        begin
                            state_next = tbl_full ? BK_OUT : BK_SHU_RD;
                        end
                    end
                    KIND_REMOVE:
                    begin
                        if (rm_hit)
                            state_next = idx_last ? BK_REC_START : BK_SHD_RD;
                        else
                            state_next = idx_last ? BK_OUT : BK_SCAN_RD;
                    end
                    KIND_TO_TIME: state_next = idx_last ? BK_TK_BL : BK_SCAN_RD;
                    KIND_TO_TICK: state_next = idx_last ? BK_TM_BL : BK_SCAN_RD;
                    default:      state_next = BK_OUT;
                endcase
            end
            BK_SHU_RD:    state_next = BK_SHU_WR;
            BK_SHU_WR:    state_next = (idx_reg == p_reg) ? BK_INS_WR : BK_SHU_RD;
            BK_INS_WR:    state_next = BK_REC_START;
            BK_SHD_RD:    state_next = BK_SHD_WR;
            BK_SHD_WR:    state_next = idx_last ? BK_REC_START : BK_SHD_RD;
            BK_REC_START: state_next = BK_REC_PREV;
            BK_REC_PREV:  state_next = (count_reg == CW'(1)) ? BK_REC_DONE : BK_REC_RD;
            BK_REC_RD:    state_next = BK_REC_LEN;
            BK_REC_LEN:   state_next = BK_DIV_WAIT;
            BK_REC_MUL:   state_next = BK_REC_ADD;
            BK_REC_ADD:   state_next = idx_last ? BK_REC_DONE : BK_REC_RD;
            BK_REC_DONE:  state_next = cfg_op_reg ? BK_IDLE : BK_OUT;
            BK_TK_BL:     state_next = BK_DIV_WAIT;
            BK_TK_TL:     state_next = BK_DIV_WAIT;
            BK_TK_Q1:     state_next = BK_DIV_WAIT;
            BK_TK_Q2:     state_next = BK_DIV_WAIT;
            BK_TK_FIN:    state_next = BK_OUT;
            BK_TM_BL:     state_next = BK_DIV_WAIT;
            BK_TM_TL:     state_next = BK_DIV_WAIT;
            BK_TM_M1:     state_next = BK_TM_M2;
            BK_TM_M2:     state_next = BK_TM_ADD;
            BK_TM_ADD:    state_next = BK_TM_FIN;
            BK_TM_FIN:    state_next = BK_OUT;
            BK_DIV_WAIT:  state_next = div_done ? ret_reg : BK_DIV_WAIT;
            BK_OUT:       state_next = out_free ? BK_IDLE : BK_OUT;
            default:      state_next = BK_IDLE;
        endcase
    end

    // Datapath and control outputs
    always_comb
    begin
        ret_next        = ret_reg;
        idx_next        = idx_reg;
        p_next          = p_reg;
        count_next      = count_reg;
        pend_next       = pend_reg;
        cfg_op_next     = cfg_op_reg;
        ovf_next        = ovf_reg;
        cmd_next        = cmd_reg;
        sel_next        = sel_reg;
        prev_next       = prev_reg;
        cur_next        = cur_reg;
        bl_next         = bl_reg;
        tl_next         = tl_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        res_status_next = res_status_reg;
        res_meas_next   = res_meas_reg;
        res_bib_next    = res_bib_reg;
        res_tib_next    = res_tib_reg;
        res_total_next  = res_total_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        pop             = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = e;
        ram_raddr       = idx_reg;
        div_start       = 1'b0;
        div_dvd         = '0;
        div_dvs         = '0;

        unique case (state_reg)
            BK_INIT:
            begin
                // Entry 0 is the 4/4 signature at bar zero after reset.
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = DEFAULT_ENTRY;
            end
            BK_IDLE:
            begin
                if (pend_reg)
                begin
                    pend_next   = 1'b0;
                    cfg_op_next = 1'b1;
                end
                else if (!fr_stat.empty)
                begin
                    pop             = 1'b1;
                    cmd_next        = head;
                    cfg_op_next     = 1'b0;
                    idx_next        = '0;
                    res_status_next = head.imm ? head.imm_status : ST_OK;
                    res_meas_next   = '0;
                    res_bib_next    = '0;
                    res_tib_next    = '0;
                    res_total_next  = head.imm ? head.imm_total : '0;
                end
            end
            BK_SCAN_CHK:
            begin
                unique case (cmd_reg.kind)
                    KIND_SET:
                    begin
                        if (bar_lt)
                        begin
                            if (!idx_last)
                                idx_next = idx_reg + IW'(1);
                            else
                            begin
                                p_next = IW'(count_reg);
                                if (tbl_full)
                                    res_status_next = ST_FULL;
                            end
                        end
                        else if (bar_eq)
                        begin
                            if (!set_same)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = idx_reg;
                                ram_wdata = '{start: e.start, den: cmd_reg.den,
                                              num: cmd_reg.num, bar: e.bar};
                            end
                        end
                        else
                        begin
                            p_next = idx_reg;
                            if (tbl_full)
                                res_status_next = ST_FULL;
                            else
                                idx_next = IW'(count_reg - CW'(1));
                        end
                    end
                    KIND_REMOVE:
                    begin
                        if (rm_hit)
                        begin
                            p_next = idx_reg;
                            if (idx_last)
                                count_next = count_reg - CW'(1);
                            else
                                idx_next = idx_reg + IW'(1);
                        end
                        else if (idx_last)
                            res_status_next = ST_NO_SIG;
                        else
                            idx_next = idx_reg + IW'(1);
                    end
                    KIND_TO_TIME:
                    begin
                        if ((idx_reg == '0) || (e.start <= cmd_reg.tick))
                            sel_next = e;
                        if (!idx_last)
                            idx_next = idx_reg + IW'(1);
                    end
                    KIND_TO_TICK:
                    begin
                        if ((idx_reg == '0) || (e.bar <= cmd_reg.bar))
                            sel_next = e;
                        if (!idx_last)
                            idx_next = idx_reg + IW'(1);
                    end
                    default:
                    begin
                        res_status_next = ST_OK;
                    end
                endcase
            end
            BK_SHU_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg + IW'(1);
                ram_wdata = e;
                if (idx_reg != p_reg)
                    idx_next = idx_reg - IW'(1);
            end
            BK_INS_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = p_reg;
                ram_wdata  = '{start: 31'd0, den: cmd_reg.den, num: cmd_reg.num,
                               bar: cmd_reg.bar};
                count_next = count_reg + CW'(1);
            end
            BK_SHD_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg - IW'(1);
                ram_wdata = e;
                if (idx_last)
                    count_next = count_reg - CW'(1);
                else
                    idx_next = idx_reg + IW'(1);
            end
            BK_REC_START:
            begin
                ram_raddr = '0;
                ovf_next  = 1'b0;
                idx_next  = IW'(1);
            end
            BK_REC_PREV:
            begin
                prev_next = e;
            end
            BK_REC_LEN:
            begin
                cur_next  = e;
                div_start = 1'b1;
                div_dvd   = 32'(bar_dvd(tpq, prev_reg.num));
                div_dvs   = 32'(prev_reg.den);
                ret_next  = BK_REC_MUL;
            end
            BK_REC_MUL:
            begin
                prod_next = 41'(bar_diff) * 41'(div_q[24:0]);
            end
            BK_REC_ADD:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = '{start: rec_start, den: cur_reg.den, num: cur_reg.num,
                              bar: cur_reg.bar};
                prev_next = '{start: rec_start, den: cur_reg.den, num: cur_reg.num,
                              bar: cur_reg.bar};
                if (rec_sum > 43'(TICK_MAX))
                    ovf_next = 1'b1;
                if (!idx_last)
                    idx_next = idx_reg + IW'(1);
            end
            BK_REC_DONE:
            begin
                if (!cfg_op_reg)
                    res_status_next = ovf_reg ? ST_OVF : ST_OK;
            end
            BK_TK_BL, BK_TM_BL:
            begin
                div_start = 1'b1;
                div_dvd   = 32'(bar_dvd(tpq, sel_reg.num));
                div_dvs   = 32'(sel_reg.den);
                ret_next  = (state_reg == BK_TK_BL) ? BK_TK_TL : BK_TM_TL;
            end
            BK_TK_TL:
            begin
                // A zero length is taken as one in the tick-to-time divisions.
                bl_next   = (div_q == '0) ? 25'd1 : div_q[24:0];
                div_start = 1'b1;
                div_dvd   = 32'({tpq, 2'b00});
                div_dvs   = 32'(sel_reg.den);
                ret_next  = BK_TK_Q1;
            end
            BK_TK_Q1:
            begin
                tl_next   = (div_q == '0) ? 25'd1 : div_q[24:0];
                div_start = 1'b1;
                div_dvd   = 32'(cmd_reg.tick - sel_reg.start);
                div_dvs   = 32'(bl_reg);
                ret_next  = BK_TK_Q2;
            end
            BK_TK_Q2:
            begin
                if (meas_sum > 32'(TICK_MAX))
                begin
                    res_meas_next   = TICK_MAX;
                    res_status_next = ST_OVF;
                end
                else
                    res_meas_next = meas_sum[30:0];
                div_start = 1'b1;
                div_dvd   = div_r;
                div_dvs   = 32'(tl_reg);
                ret_next  = BK_TK_FIN;
            end
            BK_TK_FIN:
            begin
                res_bib_next = div_q[15:0];
                res_tib_next = div_r[30:0];
            end
            BK_TM_TL:
            begin
                bl_next   = div_q[24:0];
                div_start = 1'b1;
                div_dvd   = 32'({tpq, 2'b00});
                div_dvs   = 32'(sel_reg.den);
                ret_next  = BK_TM_M1;
            end
            BK_TM_M1:
            begin
                tl_next   = div_q[24:0];
                acc_next  = 43'(cmd_reg.tick) + 43'(sel_reg.start);
                prod_next = 41'(bar_diff) * 41'(bl_reg);
            end
            BK_TM_M2:
            begin
                acc_next  = acc_reg + 43'(prod_reg);
                prod_next = 41'(cmd_reg.beat) * 41'(tl_reg);
            end
            BK_TM_ADD:
            begin
                acc_next = acc_reg + 43'(prod_reg);
            end
            BK_TM_FIN:
            begin
                if (acc_reg > 43'(TICK_MAX))
                begin
                    res_total_next  = TICK_MAX;
                    res_status_next = ST_OVF;
                end
                else
                    res_total_next = acc_reg[30:0];
            end
            BK_OUT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, res_total_reg, res_tib_reg, res_bib_reg,
                                     res_meas_reg, res_status_reg};
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase

        if (cfg_we)
            pend_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_INIT;
            ret_reg      <= BK_IDLE;
            count_reg    <= CW'(1);
            pend_reg     <= 1'b0;
            cfg_op_reg   <= 1'b0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            count_reg    <= count_next;
            pend_reg     <= pend_next;
            cfg_op_reg   <= cfg_op_next;
            ovf_reg      <= ovf_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        p_reg          <= p_next;
        cmd_reg        <= cmd_next;
        sel_reg        <= sel_next;
        prev_reg       <= prev_next;
        cur_reg        <= cur_next;
        bl_reg         <= bl_next;
        tl_reg         <= tl_next;
        prod_reg       <= prod_next;
        acc_reg        <= acc_next;
        res_status_reg <= res_status_next;
        res_meas_reg   <= res_meas_next;
        res_bib_reg    <= res_bib_next;
        res_tib_reg    <= res_tib_next;
        res_total_reg  <= res_total_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
endmodule

// ===== sv/time_signature_tick_converter_core.sv =====
// Time-signature tick converter: top level with the resolution register.
// Converts between absolute ticks and measure/beat/tick using a sorted table of
// time-signature changes kept in one RAM. Items are queued two deep in front of
// a sequential engine; one result transaction follows each input transaction.
// A table scan reads and checks each stored change in turn; an insert or removal
// moves entries one at a time with a read and a write each, and the start ticks of
// every change after entry 0 are then recomputed, using the serial divider to
// derive each bar length. A tick-to-time query takes a scan plus four divisions,
// a time-to-tick query a scan plus two divisions. A write of ticks_per_quarter
// recomputes every start tick before the next item is started. After reset the
// init state writes the 4/4 entry at bar zero.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module time_signature_tick_converter_core #(
    parameter int MAX_CHANGES = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // bar[15:0], sig_numerator[22:16], sig_denominator[29:23], beat[45:30],
    // tick[76:46], zero padding above
    input  logic [79:0]  s_tdata,
    // kind[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], measure[32:2], beat_in_bar[48:33], tick_in_beat[79:49],
    // total_tick[110:80], zero padding above
    output logic [111:0] m_tdata,
    input  logic         cfg_wr_en,
    input  logic [15:0]  cfg_wr_data
);
    import tsc_pkg::*;

    logic [15:0]  tpq_reg, tpq_next;
    cmd_t         head;
    front_stat_t  fr_stat;
    logic         pop;

    assign tpq_next = cfg_wr_en ? cfg_wr_data : tpq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpq_reg <= 16'd480;
        end
        else
        begin
            tpq_reg <= tpq_next;
        end
    end

    tsc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .pop      (pop),
        .head     (head),
        .stat     (fr_stat)
    );

    tsc_back #(.MAX_CHANGES(MAX_CHANGES)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .tpq      (tpq_reg),
        .cfg_we   (cfg_wr_en),
        .head     (head),
        .fr_stat  (fr_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    `ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && fr_stat.empty, "pop from an empty queue")
    `ASSERT_NEVER(a_ready_full, clk, rst_n, !s_tready && !fr_stat.full, "ready low with room")
    `ASSERT_CLK(a_cfg_first, clk, rst_n, cfg_wr_en |=> !pop, "item started before recompute")
endmodule
